FILE: rtl/ffea_pkg.sv
package ffea_pkg;

  localparam int MEM_UNITS   = 1024;
  localparam int MAX_EXTENTS = 16;

  // address, size, extent count and list index widths
  localparam int AW = $clog2(MEM_UNITS);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);

  // command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // result status codes
  localparam logic [1:0] ST_GRANTED = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // opcode values
  localparam logic OP_ALLOC = 1'b0;

  // command classes produced by the front
  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_FREE_NOP = 2'd1,
    KIND_FREE_ADD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [SW-1:0]   size;
    logic [AW-1:0]   start;
    logic [AW-1:0]   last;
  } cmd_t;

  typedef struct packed {
    logic [AW-1:0] first;
    logic [AW-1:0] last;
  } ext_t;

endpackage

FILE: rtl/ffea_front.sv
module ffea_front (
  input  logic                  start,
  input  logic                  opcode,
  input  logic [ffea_pkg::SW-1:0] block_size,
  input  logic [ffea_pkg::AW-1:0] block_start,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output ffea_pkg::cmd_t        cmd
);

  logic [ffea_pkg::SW:0] end_sum;
  logic                  start_oob;

  // transfer when the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // inclusive end of a freed block, saturated at the top of memory
  assign end_sum   = {1'b0, ffea_pkg::SW'(block_start)} + {1'b0, block_size}
                     - (ffea_pkg::SW + 1)'(1);
  assign start_oob = (ffea_pkg::SW'(block_start) >= ffea_pkg::SW'(ffea_pkg::MEM_UNITS));

  // classify the item
  always_comb begin
    cmd.size  = block_size;
    cmd.start = block_start;
    if (end_sum > (ffea_pkg::SW + 1)'(ffea_pkg::MEM_UNITS - 1)) begin
      cmd.last = ffea_pkg::AW'(ffea_pkg::MEM_UNITS - 1);
    end else begin
      cmd.last = end_sum[ffea_pkg::AW-1:0];
    end
    if (opcode == ffea_pkg::OP_ALLOC) begin
      cmd.kind = ffea_pkg::KIND_ALLOC;
    end else if (block_size == '0 || start_oob) begin
      cmd.kind = ffea_pkg::KIND_FREE_NOP;
    end else begin
      cmd.kind = ffea_pkg::KIND_FREE_ADD;
    end
  end

endmodule

FILE: rtl/ffea_queue.sv
module ffea_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ffea_pkg::cmd_t push_data,
  input  logic           pop,
  output logic           q_valid,
  output ffea_pkg::cmd_t q_data,
  output logic           q_full
);

  ffea_pkg::cmd_t               mem [ffea_pkg::QDEPTH];
  logic [ffea_pkg::QPW-1:0]     wptr;
  logic [ffea_pkg::QPW-1:0]     rptr;
  logic [ffea_pkg::QCW-1:0]     fill;

  assign q_valid = (fill != '0);
  assign q_full  = (fill == ffea_pkg::QCW'(ffea_pkg::QDEPTH));
  assign q_data  = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == ffea_pkg::QPW'(ffea_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == ffea_pkg::QPW'(ffea_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

FILE: rtl/ffea_back.sv
module ffea_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  ffea_pkg::cmd_t          q_data,
  output logic                    pop,
  output logic                    result_valid,
  output logic [1:0]              status,
  output logic [ffea_pkg::AW-1:0] granted_address
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                   state;
  ffea_pkg::cmd_t           cmd;
  ffea_pkg::ext_t           ext [ffea_pkg::MAX_EXTENTS];
  logic [ffea_pkg::CW-1:0]  count;
  logic [ffea_pkg::CW-1:0]  scan_cnt;

  logic [ffea_pkg::SW-1:0]  head_len;
  logic                     head_fit;
  logic                     has_rem;
  logic [ffea_pkg::CW-1:0]  count_m1;
  logic [ffea_pkg::CW-1:0]  rem_pos;
  ffea_pkg::ext_t           rem_ext;

  assign pop = (state == S_IDLE) && q_valid;

  // head extent test; the scan rotates the list so the candidate is always at the head
  assign head_len = {1'b0, ext[0].last} - {1'b0, ext[0].first} + ffea_pkg::SW'(1);
  assign head_fit = (head_len >= cmd.size);
  assign has_rem  = (head_len > cmd.size);
  assign count_m1 = count - 1'b1;
  assign rem_pos  = count_m1 - scan_cnt;
  assign rem_ext.first = ffea_pkg::AW'({1'b0, ext[0].first} + cmd.size);
  assign rem_ext.last  = ext[0].last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= ffea_pkg::CW'(1);
      scan_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            scan_cnt <= '0;
            case (q_data.kind)
              ffea_pkg::KIND_ALLOC: begin
                state <= S_SCAN;
              end
              ffea_pkg::KIND_FREE_ADD: begin
                result_valid <= 1'b1;
                if (count < ffea_pkg::CW'(ffea_pkg::MAX_EXTENTS)) begin
                  count <= count + 1'b1;
                end
              end
              default: begin
                result_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt == count) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (head_fit) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
            if (!has_rem) begin
              count <= count_m1;
            end
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command register and result fields
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_data;
    end
    case (state)
      S_IDLE: begin
        granted_address <= '0;
        if (q_data.kind == ffea_pkg::KIND_FREE_ADD &&
            count >= ffea_pkg::CW'(ffea_pkg::MAX_EXTENTS)) begin
          status <= ffea_pkg::ST_FULL;
        end else begin
          status <= ffea_pkg::ST_FREED;
        end
      end
      default: begin
        if (scan_cnt != count && head_fit) begin
          status          <= ffea_pkg::ST_GRANTED;
          granted_address <= ext[0].first;
        end else begin
          status          <= ffea_pkg::ST_NOFIT;
          granted_address <= '0;
        end
      end
    endcase
  end

  // extent list: append on free, rotate while scanning, splice on a hit
  always_ff @(posedge clk) begin
    if (rst) begin
      ext[0].first <= '0;
      ext[0].last  <= ffea_pkg::AW'(ffea_pkg::MEM_UNITS - 1);
    end else begin
      for (int i = 0; i < ffea_pkg::MAX_EXTENTS; i++) begin
        if (state == S_IDLE) begin
          if (q_valid && q_data.kind == ffea_pkg::KIND_FREE_ADD &&
              count == ffea_pkg::CW'(i)) begin
            ext[i].first <= q_data.start;
            ext[i].last  <= q_data.last;
          end
        end else if (scan_cnt != count) begin
          if (head_fit) begin
            if (has_rem) begin
              if (ffea_pkg::CW'(i) < rem_pos) begin
                ext[i] <= ext[(i + 1) % ffea_pkg::MAX_EXTENTS];
              end else if (ffea_pkg::CW'(i) == rem_pos) begin
                ext[i] <= rem_ext;
              end
            end else if (ffea_pkg::CW'(i) < count_m1) begin
              ext[i] <= ext[(i + 1) % ffea_pkg::MAX_EXTENTS];
            end
          end else begin
            if (ffea_pkg::CW'(i) < count_m1) begin
              ext[i] <= ext[(i + 1) % ffea_pkg::MAX_EXTENTS];
            end else if (ffea_pkg::CW'(i) == count_m1) begin
              ext[i] <= ext[0];
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/first_fit_extent_allocator_unit.sv
// First-fit extent allocator. Raise start for one cycle with opcode (0 allocate,
// 1 free), block_size and block_start; the item transfers when busy is low. Each
// item gives exactly one result, shown for a single cycle with result_valid high;
// the receiver cannot stall it, so it must take status and granted_address then.
// A free passes through the command queue and then the registered result. An
// allocate tests one extent per cycle at the head of the list, up to the first
// one that fits or, when nothing fits, every extent in the list. A two-entry
// command queue lets up to two further items transfer while a scan runs; busy
// rises when it is full.
module first_fit_extent_allocator_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode,
  input  logic [ffea_pkg::SW-1:0] block_size,
  input  logic [ffea_pkg::AW-1:0] block_start,
  output logic                    result_valid,
  output logic [1:0]              status,
  output logic [ffea_pkg::AW-1:0] granted_address
);

  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  ffea_pkg::cmd_t push_cmd;
  ffea_pkg::cmd_t q_cmd;

  ffea_front u_front (
    .start       (start),
    .opcode      (opcode),
    .block_size  (block_size),
    .block_start (block_start),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .cmd         (push_cmd)
  );

  ffea_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_cmd),
    .q_full    (q_full)
  );

  ffea_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_cmd),
    .pop             (pop),
    .result_valid    (result_valid),
    .status          (status),
    .granted_address (granted_address)
  );

endmodule
